// ----- rtl/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Holds payload structs, operation and status codes, and the job record that
// the front stage hands to the reduction engine.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned FieldWidth   = 32;
  localparam int unsigned DenWidth     = 31;
  localparam int unsigned ProdWidth    = 2 * FieldWidth;
  localparam int unsigned MagWidth     = ProdWidth + 1;
  localparam int unsigned QueueDepth   = 2;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]             operation;
    logic signed [FieldWidth-1:0] left_num;
    logic signed [FieldWidth-1:0] left_den;
    logic signed [FieldWidth-1:0] right_num;
    logic signed [FieldWidth-1:0] right_den;
  } in_item_t;

  typedef struct packed {
    logic signed [FieldWidth-1:0] result_num;
    logic [DenWidth-1:0]          result_den;
    logic [1:0]                   status;
  } out_item_t;

  // unreduced fraction in sign-magnitude form, or an early zero-denominator flag
  typedef struct packed {
    logic                zero_den;
    logic                num_neg;
    logic [MagWidth-1:0] num_mag;
    logic [MagWidth-1:0] den_mag;
  } job_t;

  typedef enum logic [2:0] {
    BE_IDLE,
    BE_GCD,
    BE_DIVN,
    BE_DIVD,
    BE_DONE
  } be_state_e;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_MUL,
    FE_SUM
  } fe_state_e;

endpackage

// ----- rtl/rau_ram.sv -----
// ----------------------------------------------------------------------------
// rau_ram: generic single-write, single-read RAM
// Registered read port, no reset on the storage.
// ----------------------------------------------------------------------------
module rau_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/rau_front.sv -----
// ----------------------------------------------------------------------------
// rau_front: operand decode and cross multiplication
// Sign-extends operands, checks zero denominators, forms the exact
// numerator and denominator step by step with one shared multiplier.
// ----------------------------------------------------------------------------
module rau_front #(
  parameter int unsigned OperandWidth = rau_pkg::OperandWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rau_pkg::in_item_t item_i,
  input  logic             push_i,
  output logic             full_o,
  output rau_pkg::job_t    job_o,
  output logic             job_valid_o,
  input  logic             job_ready_i
);

  localparam int unsigned FW = rau_pkg::FieldWidth;
  localparam int unsigned PW = rau_pkg::ProdWidth;
  localparam int unsigned MW = rau_pkg::MagWidth;

  rau_pkg::fe_state_e state_q, state_d;

  logic [1:0]    op_q;
  logic [FW-1:0] ln_q, ld_q, rn_q, rd_q;
  logic          lnn_q, ldn_q, rnn_q, rdn_q;
  logic [1:0]    step_q, step_d;
  logic [PW-1:0] pa_q, pb_q, pd_q;
  logic          zd_q;
  logic [PW-1:0] prod;
  logic [FW-1:0] ma, mb;
  rau_pkg::job_t job_d;

  // sign-extend the low operand bits and take the magnitude
  function automatic logic [FW:0] dec(input logic [FW-1:0] raw);
    logic [FW-1:0] v;
    logic          n;
    v = FW'($signed(raw[OperandWidth-1:0]));
    n = v[FW-1];
    dec = {n, n ? (~v + FW'(1)) : v};
  endfunction

  logic [FW:0] dln, dld, drn, drd;
  assign dln = dec(item_i.left_num);
  assign dld = dec(item_i.left_den);
  assign drn = dec(item_i.right_num);
  assign drd = dec(item_i.right_den);

  // multiplier operand select per step: 0 num-a, 1 num-b, 2 den
  always_comb begin
    ma = ln_q;
    mb = rd_q;
    case (step_q)
      2'd0: begin
        ma = ln_q;
        mb = (op_q == rau_pkg::OP_MUL) ? rn_q : rd_q;
      end
      2'd1: begin
        ma = rn_q;
        mb = ld_q;
      end
      default: begin
        ma = ld_q;
        mb = (op_q == rau_pkg::OP_DIV) ? rn_q : rd_q;
      end
    endcase
  end
  assign prod = PW'(ma) * PW'(mb);

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      rau_pkg::FE_IDLE: begin
        if (push_i) begin
          state_d = rau_pkg::FE_MUL;
          step_d  = 2'd0;
        end
      end
      rau_pkg::FE_MUL: begin
        if (zd_q) begin
          state_d = rau_pkg::FE_SUM;
        end else if (step_q == 2'd2) begin
          state_d = rau_pkg::FE_SUM;
        end else if (step_q == 2'd0 &&
                     (op_q == rau_pkg::OP_MUL || op_q == rau_pkg::OP_DIV)) begin
          step_d = 2'd2;
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      rau_pkg::FE_SUM: begin
        if (job_ready_i) state_d = rau_pkg::FE_IDLE;
      end
      default: state_d = rau_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::FE_IDLE;
      step_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == rau_pkg::FE_IDLE && push_i) begin
      op_q  <= item_i.operation;
      {lnn_q, ln_q} <= dln;
      {ldn_q, ld_q} <= dld;
      {rnn_q, rn_q} <= drn;
      {rdn_q, rd_q} <= drd;
      zd_q  <= (dld[FW-1:0] == '0) || (drd[FW-1:0] == '0) ||
               (item_i.operation == rau_pkg::OP_DIV && drn[FW-1:0] == '0);
    end else if (state_q == rau_pkg::FE_MUL) begin
      case (step_q)
        2'd0:    pa_q <= prod;
        2'd1:    pb_q <= prod;
        default: pd_q <= prod;
      endcase
    end
  end

  // sum of signed cross products (mul/div: pa only); then apply den sign
  logic          sa, sb, sd;
  logic [MW-1:0] num_mag;
  logic          num_neg;
  always_comb begin
    sa = lnn_q ^ ((op_q == rau_pkg::OP_MUL) ? rnn_q : rdn_q);
    sb = rnn_q ^ ldn_q ^ (op_q == rau_pkg::OP_SUB);
    sd = ldn_q ^ ((op_q == rau_pkg::OP_DIV) ? rnn_q : rdn_q);
    if (op_q == rau_pkg::OP_MUL || op_q == rau_pkg::OP_DIV) begin
      num_mag = MW'(pa_q);
      num_neg = sa;
    end else if (sa == sb) begin
      num_mag = MW'(pa_q) + MW'(pb_q);
      num_neg = sa;
    end else if (pa_q >= pb_q) begin
      num_mag = MW'(pa_q - pb_q);
      num_neg = sa;
    end else begin
      num_mag = MW'(pb_q - pa_q);
      num_neg = sb;
    end
    job_d.zero_den = zd_q;
    job_d.num_mag  = num_mag;
    job_d.den_mag  = MW'(pd_q);
    job_d.num_neg  = (num_mag != '0) && (num_neg ^ sd);
  end

  assign job_o       = job_d;
  assign job_valid_o = (state_q == rau_pkg::FE_SUM);
  assign full_o      = (state_q != rau_pkg::FE_IDLE);

endmodule

// ----- rtl/rau_queue.sv -----
// ----------------------------------------------------------------------------
// rau_queue: small FIFO between the front stage and the reduction engine
// Storage is a generic RAM with registered read; a prefetch register
// holds the head entry.
// ----------------------------------------------------------------------------
module rau_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = rau_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [Width-1:0] wdata_i,
  input  logic             push_i,
  output logic             ready_o,
  output logic [Width-1:0] rdata_o,
  output logic             valid_o,
  input  logic             pop_i
);

  localparam int unsigned AW = $clog2(Depth);

  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;
  logic          head_q;
  logic          rd_pend_q;
  logic [Width-1:0] ram_rdata, head_data_q;
  logic          do_push, do_pop, fetch;

  assign ready_o = (cnt_q != (AW+1)'(Depth));
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && head_q;
  // fetch the next entry when the head slot is or becomes free
  assign fetch   = (cnt_q != '0) && !rd_pend_q && (!head_q || do_pop);

  rau_ram #(.Width(Width), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (wptr_q),
    .wdata_i (wdata_i),
    .raddr_i (rptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q    <= '0;
      rptr_q    <= '0;
      cnt_q     <= '0;
      head_q    <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == AW'(Depth-1)) ? '0 : wptr_q + AW'(1);
      if (fetch)   rptr_q <= (rptr_q == AW'(Depth-1)) ? '0 : rptr_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(fetch);
      rd_pend_q <= fetch;
      if (rd_pend_q)   head_q <= 1'b1;
      else if (do_pop) head_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) head_data_q <= ram_rdata;
  end

  assign rdata_o = head_data_q;
  assign valid_o = head_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth)) else $error("queue count beyond depth");
  a_fetch_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fetch |=> rd_pend_q ##1 head_q) else $error("fetched entry not at head");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !head_q || $past(do_pop)) else $error("head overwritten");
`endif

endmodule

// ----- rtl/rau_back.sv -----
// ----------------------------------------------------------------------------
// rau_back: Euclidean reduction engine
// Binary-free Euclid with a restoring remainder unit, one quotient bit per
// cycle, then two divisions by the gcd and a range check.
// ----------------------------------------------------------------------------
module rau_back #(
  parameter int unsigned OperandWidth = rau_pkg::OperandWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rau_pkg::job_t      job_i,
  input  logic               job_valid_i,
  output logic               job_pop_o,
  output rau_pkg::out_item_t res_o,
  output logic               empty_o,
  input  logic               pop_i
);

  localparam int unsigned MW = rau_pkg::MagWidth;
  localparam int unsigned FW = rau_pkg::FieldWidth;
  localparam int unsigned CW = $clog2(MW + 1);
  localparam logic [MW-1:0] Half = MW'(1) << (OperandWidth - 1);

  rau_pkg::be_state_e state_q, state_d;

  logic [MW-1:0] p_q, q_q;          // euclid pair
  logic [MW-1:0] n_q, d_q, g_q;
  logic          neg_q, zd_q;
  // long division unit: dividend shifts out, remainder builds up
  logic [MW-1:0] dv_q, rm_q, qt_q;
  logic [CW-1:0] bit_q;
  logic [MW:0]   trial;
  logic          div_last;
  rau_pkg::out_item_t res_q;
  logic          full_q;

  assign trial    = {rm_q, dv_q[MW-1]} - {1'b0, (state_q == rau_pkg::BE_GCD) ? q_q : g_q};
  assign div_last = (bit_q == CW'(MW - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      rau_pkg::BE_IDLE: begin
        if (job_valid_i && !full_q) begin
          state_d = (job_i.zero_den || job_i.num_mag == '0) ?
                    rau_pkg::BE_DONE : rau_pkg::BE_GCD;
        end
      end
      rau_pkg::BE_GCD: begin
        if (q_q == '0) state_d = rau_pkg::BE_DIVN;
      end
      rau_pkg::BE_DIVN: begin
        if (div_last) state_d = rau_pkg::BE_DIVD;
      end
      rau_pkg::BE_DIVD: begin
        if (div_last) state_d = rau_pkg::BE_DONE;
      end
      rau_pkg::BE_DONE: state_d = rau_pkg::BE_IDLE;
      default:          state_d = rau_pkg::BE_IDLE;
    endcase
  end

  assign job_pop_o = (state_q == rau_pkg::BE_IDLE) && job_valid_i && !full_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::BE_IDLE;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == rau_pkg::BE_DONE) full_q <= 1'b1;
      else if (pop_i)                  full_q <= 1'b0;
    end
  end

  logic [MW-1:0] rm_nx, qt_nx;
  always_comb begin
    if (!trial[MW]) begin
      rm_nx = trial[MW-1:0];
      qt_nx = {qt_q[MW-2:0], 1'b1};
    end else begin
      rm_nx = {rm_q[MW-2:0], dv_q[MW-1]};
      qt_nx = {qt_q[MW-2:0], 1'b0};
    end
  end

  logic fits;
  logic [FW-1:0] num_out;
  always_comb begin
    fits = (d_q <= Half - MW'(1)) && (neg_q ? (n_q <= Half) : (n_q <= Half - MW'(1)));
    num_out = neg_q ? FW'(~n_q + MW'(1)) : FW'(n_q);
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rau_pkg::BE_IDLE: begin
        p_q   <= job_i.num_mag;
        q_q   <= job_i.den_mag;
        n_q   <= job_i.num_mag;
        d_q   <= job_i.den_mag;
        neg_q <= job_i.num_neg;
        zd_q  <= job_i.zero_den;
        dv_q  <= job_i.num_mag;
        rm_q  <= '0;
        bit_q <= '0;
        // zero numerator reduces straight to 0/1
        if (job_i.num_mag == '0) d_q <= MW'(1);
      end
      rau_pkg::BE_GCD: begin
        if (q_q == '0) begin
          g_q   <= p_q;
          dv_q  <= n_q;
          rm_q  <= '0;
          bit_q <= '0;
        end else begin
          rm_q  <= rm_nx;
          dv_q  <= {dv_q[MW-2:0], 1'b0};
          bit_q <= bit_q + CW'(1);
          if (div_last) begin
            p_q   <= q_q;
            q_q   <= rm_nx;
            dv_q  <= q_q;
            rm_q  <= '0;
            bit_q <= '0;
          end
        end
      end
      rau_pkg::BE_DIVN, rau_pkg::BE_DIVD: begin
        rm_q  <= rm_nx;
        qt_q  <= qt_nx;
        dv_q  <= {dv_q[MW-2:0], 1'b0};
        bit_q <= bit_q + CW'(1);
        if (div_last) begin
          bit_q <= '0;
          rm_q  <= '0;
          if (state_q == rau_pkg::BE_DIVN) begin
            n_q  <= qt_nx;
            dv_q <= d_q;
          end else begin
            d_q <= qt_nx;
          end
        end
      end
      rau_pkg::BE_DONE: begin
        if (zd_q) begin
          res_q <= '{result_num: '0, result_den: '0, status: rau_pkg::ST_ZERO_DEN};
        end else if (!fits) begin
          res_q <= '{result_num: '0, result_den: '0, status: rau_pkg::ST_OVERFLOW};
        end else begin
          res_q <= '{result_num: $signed(num_out), result_den: rau_pkg::DenWidth'(d_q),
                     status: rau_pkg::ST_OK};
        end
      end
      default: ;
    endcase
  end

  assign res_o   = res_q;
  assign empty_o = !full_q;

`ifndef ASSERT_OFF
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> !full_q) else $error("job taken while result pending");
  a_done_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == rau_pkg::BE_DONE |=> full_q) else $error("result not posted");
  a_ok_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q && res_q.status == rau_pkg::ST_OK |-> res_q.result_den != '0)
    else $error("zero denominator with ok status");
`endif

endmodule

// ----- rtl/rational_arithmetic_unit.sv -----
// Zero denominators and zero numerators skip the Euclid steps; other items run
// the Euclid remainder steps, then divide numerator and denominator by the gcd.
// While the back stage works on one item, the front stage and a two-entry queue
// prepare the next items.
// Reset: asynchronous active low, clears all control state; no result pending.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: rational add, subtract, multiply and divide
// Cross multiplies, normalizes the sign and reduces by the gcd.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int unsigned OperandWidth = rau_pkg::OperandWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rau_pkg::in_item_t  in_i,
  input  logic               push,
  output logic               full,
  output rau_pkg::out_item_t out_o,
  output logic               empty,
  input  logic               pop
);

  localparam int unsigned JW = $bits(rau_pkg::job_t);

  rau_pkg::job_t f_job, q_job;
  logic          f_valid, f_ready, q_valid, q_pop;

  rau_front #(.OperandWidth(OperandWidth)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_i),
    .push_i      (push),
    .full_o      (full),
    .job_o       (f_job),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready)
  );

  rau_queue #(.Width(JW), .Depth(rau_pkg::QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wdata_i (f_job),
    .push_i  (f_valid),
    .ready_o (f_ready),
    .rdata_o (q_job),
    .valid_o (q_valid),
    .pop_i   (q_pop)
  );

  rau_back #(.OperandWidth(OperandWidth)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job),
    .job_valid_i (q_valid),
    .job_pop_o   (q_pop),
    .res_o       (out_o),
    .empty_o     (empty),
    .pop_i       (pop)
  );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the rational arithmetic unit
// Pushes directed and random rational operations through the block. A
// scoreboard works out the reduced fraction for each accepted operation and
// checks every popped result against it, in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned NumRandom  = 1300;
  localparam longint      CycleLimit = 30_000_000;
  localparam int unsigned DrainWait  = 8000;

  class fraction_board;
    rau_pkg::out_item_t pending_q[$];
    int unsigned fail_count = 0;

    // low 32 bits to sign and magnitude
    function void split(input logic [31:0] raw, output bit neg,
                        output longint unsigned mag);
      neg = raw[31];
      mag = neg ? longint'(~raw + 32'd1) & 64'hffff_ffff : longint'(raw);
      if (neg && mag == 0) mag = 64'h8000_0000;
    endfunction

    function void sm_prod(input bit an, input longint unsigned am,
                          input bit bn, input longint unsigned bm,
                          output bit rn, output longint unsigned rm);
      rm = am * bm;
      rn = (rm != 0) && (an != bn);
    endfunction

    function rau_pkg::out_item_t reduce(rau_pkg::in_item_t it);
      rau_pkg::out_item_t r;
      bit ln, ld, rn, rd, nn, dn, an, bn;
      longint unsigned lm, ldm, rm, rdm, nm, dm, am, bm, p, q, t;
      r = '0;
      split(it.left_num, ln, lm);
      split(it.left_den, ld, ldm);
      split(it.right_num, rn, rm);
      split(it.right_den, rd, rdm);
      if (ldm == 0 || rdm == 0 ||
          (rau_pkg::op_e'(it.operation) == rau_pkg::OP_DIV && rm == 0)) begin
        r.status = rau_pkg::ST_ZERO_DEN;
        return r;
      end
      case (rau_pkg::op_e'(it.operation))
        rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
          sm_prod(ln, lm, rd, rdm, an, am);
          sm_prod(rn, rm, ld, ldm, bn, bm);
          if (rau_pkg::op_e'(it.operation) == rau_pkg::OP_SUB && bm != 0) bn = !bn;
          if (an == bn) begin
            nm = am + bm;
            nn = an;
          end else if (am >= bm) begin
            nm = am - bm;
            nn = an;
          end else begin
            nm = bm - am;
            nn = bn;
          end
          if (nm == 0) nn = 0;
          sm_prod(ld, ldm, rd, rdm, dn, dm);
        end
        rau_pkg::OP_MUL: begin
          sm_prod(ln, lm, rn, rm, nn, nm);
          sm_prod(ld, ldm, rd, rdm, dn, dm);
        end
        default: begin
          sm_prod(ln, lm, rd, rdm, nn, nm);
          sm_prod(ld, ldm, rn, rm, dn, dm);
        end
      endcase
      if (dn && nm != 0) nn = !nn;
      p = nm;
      q = dm;
      while (q != 0) begin
        t = p % q;
        p = q;
        q = t;
      end
      if (p != 0) begin
        nm = nm / p;
        dm = dm / p;
      end
      if (dm > 64'h7fff_ffff || nm > (nn ? 64'h8000_0000 : 64'h7fff_ffff)) begin
        r.status = rau_pkg::ST_OVERFLOW;
        return r;
      end
      r.result_num = nn ? 32'(-nm) : 32'(nm);
      r.result_den = 31'(dm);
      r.status     = rau_pkg::ST_OK;
      return r;
    endfunction

    function void note_push(rau_pkg::in_item_t it);
      pending_q.push_back(reduce(it));
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
    endtask

    task check_pop(rau_pkg::out_item_t got);
      rau_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        report("result with no operation outstanding");
        return;
      end
      want = pending_q.pop_front();
      if (got.result_num !== want.result_num)
        report($sformatf("result_num %0d, want %0d", got.result_num, want.result_num));
      if (got.result_den !== want.result_den)
        report($sformatf("result_den %0d, want %0d", got.result_den, want.result_den));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic               clk_i;
  logic               rst_ni;
  rau_pkg::in_item_t  in_i;
  logic               push;
  logic               full;
  rau_pkg::out_item_t out_o;
  logic               empty;
  logic               pop;

  fraction_board board;
  bit            calm;
  bit            pushing_done;
  longint        cycles;

  rational_arithmetic_unit DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_i),
    .push  (push),
    .full  (full),
    .out_o (out_o),
    .empty (empty),
    .pop   (pop)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic send(rau_pkg::op_e op, logic [31:0] a, logic [31:0] b,
                      logic [31:0] c, logic [31:0] d);
    rau_pkg::in_item_t it;
    it = {op, a, b, c, d};
    while (!calm && $urandom_range(0, 99) < 19) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_i <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    board.note_push(it);
  endtask

  // mostly short magnitudes so the gcd stays quick, with some full-width values
  function automatic logic [31:0] pick_field();
    logic [31:0] v;
    int unsigned sz;
    case ($urandom_range(0, 11))
      0:       v = 32'd0;
      1:       v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      2, 3:    v = $urandom;
      default: begin
        sz = $urandom_range(1, 16);
        v  = $urandom & ((32'd1 << sz) - 1);
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    board  = new();
    rst_ni = 1'b0;
    push   = 1'b0;
    in_i   = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(rau_pkg::OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send(rau_pkg::OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    send(rau_pkg::OP_MUL, 32'd4, -32'd6, 32'd3, 32'd8);
    send(rau_pkg::OP_DIV, 32'd5, 32'd7, -32'd10, 32'd21);
    send(rau_pkg::OP_ADD, 32'd0, 32'd0, 32'd1, 32'd1);
    send(rau_pkg::OP_SUB, 32'd1, 32'd1, 32'd1, 32'd0);
    send(rau_pkg::OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    send(rau_pkg::OP_DIV, 32'd0, 32'd4, 32'd0, 32'd5);
    send(rau_pkg::OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send(rau_pkg::OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send(rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, -32'd1, 32'd1);
    send(rau_pkg::OP_DIV, 32'h8000_0000, -32'd1, 32'd1, 32'd1);
    send(rau_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(rau_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send(rau_pkg::OP_ADD, 32'd0, -32'd7, 32'd0, 32'd3);
    send(rau_pkg::OP_MUL, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff);
    send(rau_pkg::OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send(rau_pkg::OP_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);

    for (int i = 0; i < NumRandom; i++) begin
      calm = (i >= 500 && i < 700);
      send(rau_pkg::op_e'($urandom_range(0, 3)), pick_field(), pick_field(),
           pick_field(), pick_field());
    end
    calm = 1'b0;
    push <= 1'b0;
    pushing_done = 1'b1;
  end

  // result side; pop and out_o are seen as they were before the edge
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      pop <= calm || $urandom_range(0, 99) >= 19;
      @(posedge clk_i);
      if (pop && !empty) board.check_pop(out_o);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    @(posedge clk_i);
    wait (pushing_done);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
